// ===== sv/assert_macros.svh =====
// concurrent assertion helpers, clocked and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== sv/sitoa_pkg.sv =====
package sitoa_pkg;

	localparam int VALUE_WIDTH = 32;

	// decimal digits needed for the largest magnitude, 2^(width-1)
	function automatic int digit_count(input int w);
		longint unsigned v;
		int n;
		v = 64'd1 << (w - 1);
		n = 0;
		while (v != 0) begin
			v = v / 10;
			n = n + 1;
		end
		return n;
	endfunction

	localparam int NUM_DIGITS = digit_count(VALUE_WIDTH);
	localparam int BCD_WIDTH  = 4 * NUM_DIGITS;
	localparam int BIT_CNT_W  = $clog2(VALUE_WIDTH);
	localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_MINUS = 8'h2d;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_SIGN,
		ST_EMIT
	} state_t;

	// commands to the bcd unit
	typedef struct packed {
		logic load;
		logic dabble;
		logic shift_digit;
	} bcd_ctl_t;

	// status from the bcd unit
	typedef struct packed {
		logic [3:0] top_digit;
		logic       top_zero;
	} bcd_stat_t;

endpackage

// ===== sv/sitoa_in_if.sv =====
interface sitoa_in_if import sitoa_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [VALUE_WIDTH-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

// ===== sv/sitoa_out_if.sv =====
interface sitoa_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] character;
	logic       last;

	modport source (output valid, output character, output last, input ready);
	modport sink (input valid, input character, input last, output ready);
endinterface

// ===== sv/sitoa_bcd_unit.sv =====
module sitoa_bcd_unit import sitoa_pkg::*; (
	input  logic                   clk,
	input  bcd_ctl_t               ctl,
	input  logic [VALUE_WIDTH-1:0] magnitude,
	output bcd_stat_t              stat
);

	logic [VALUE_WIDTH-1:0] mag_q;
	logic [BCD_WIDTH-1:0]   bcd_q;
	logic [BCD_WIDTH-1:0]   bcd_adj;

	// add-3 correction on every digit of five or more
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	// one binary bit in per dabble step, one digit out per digit shift
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			mag_q <= magnitude;
			bcd_q <= '0;
		end else if (ctl.dabble) begin
			mag_q <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
			bcd_q <= {bcd_adj[BCD_WIDTH-2:0], mag_q[VALUE_WIDTH-1]};
		end else if (ctl.shift_digit) begin
			bcd_q <= {bcd_q[BCD_WIDTH-5:0], 4'd0};
		end
	end

	assign stat.top_digit = bcd_q[BCD_WIDTH-1 -: 4];
	assign stat.top_zero  = (bcd_q[BCD_WIDTH-1 -: 4] == 4'd0);

endmodule

// ===== sv/signed_int_to_decimal_ascii_unit.sv =====
// signed 32-bit integer to decimal ascii, one character item per output handshake
// conversion: shift-and-add-3 in the bcd unit, one input bit a cycle
// then a leading-zero skip whose final step picks sign or digit
// an item occupies the block until its last digit is loaded for output; ready only while idle
// the first character follows the conversion and skip, and waits out any output stall
// arst_n clears the sequencer and the output valid; data registers are not reset
module signed_int_to_decimal_ascii_unit import sitoa_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	sitoa_in_if.sink     din,
	sitoa_out_if.source  dout
);

	state_t                 state_q, state_d;
	logic [BIT_CNT_W-1:0]   bit_cnt_q, bit_cnt_d;
	logic [DIG_CNT_W-1:0]   dig_cnt_q, dig_cnt_d;
	logic                   neg_q, neg_d;
	logic                   out_valid_q;
	logic [7:0]             char_q;
	logic                   last_q;
	logic                   out_load;
	logic [7:0]             out_char;
	logic                   out_last;
	logic                   out_free;
	logic [VALUE_WIDTH-1:0] magnitude;
	bcd_ctl_t               ctl;
	bcd_stat_t              stat;

	// magnitude as unsigned, exact for the most negative value
	assign magnitude = din.value[VALUE_WIDTH-1] ? (~din.value + 1'b1) : din.value;

	assign out_free = !out_valid_q || dout.ready;

	sitoa_bcd_unit u_bcd (
		.clk       (clk),
		.ctl       (ctl),
		.magnitude (magnitude),
		.stat      (stat)
	);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			dig_cnt_q <= '0;
			neg_q     <= 1'b0;
		end else begin
			state_q   <= state_d;
			bit_cnt_q <= bit_cnt_d;
			dig_cnt_q <= dig_cnt_d;
			neg_q     <= neg_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d         = state_q;
		bit_cnt_d       = bit_cnt_q;
		dig_cnt_d       = dig_cnt_q;
		neg_d           = neg_q;
		ctl             = '0;
		din.ready       = 1'b0;
		out_load        = 1'b0;
		out_char        = CHAR_MINUS;
		out_last        = 1'b0;
		case (state_q)
			ST_IDLE: begin
				din.ready = 1'b1;
				if (din.valid) begin
					ctl.load  = 1'b1;
					neg_d     = din.value[VALUE_WIDTH-1];
					bit_cnt_d = '0;
					state_d   = ST_CONV;
				end
			end
			ST_CONV: begin
				ctl.dabble = 1'b1;
				if (bit_cnt_q == BIT_CNT_W'(VALUE_WIDTH - 1)) begin
					dig_cnt_d = DIG_CNT_W'(NUM_DIGITS);
					state_d   = ST_SKIP;
				end else begin
					bit_cnt_d = bit_cnt_q + 1'b1;
				end
			end
			ST_SKIP: begin
				// drop leading zeros, always keep the last digit
				if (stat.top_zero && dig_cnt_q > DIG_CNT_W'(1)) begin
					ctl.shift_digit = 1'b1;
					dig_cnt_d       = dig_cnt_q - 1'b1;
				end else if (neg_q) begin
					state_d = ST_SIGN;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_SIGN: begin
				if (out_free) begin
					out_load = 1'b1;
					out_char = CHAR_MINUS;
					out_last = 1'b0;
					state_d  = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					out_load        = 1'b1;
					out_char        = CHAR_ZERO | {4'd0, stat.top_digit};
					out_last        = (dig_cnt_q == DIG_CNT_W'(1));
					ctl.shift_digit = 1'b1;
					dig_cnt_d       = dig_cnt_q - 1'b1;
					if (dig_cnt_q == DIG_CNT_W'(1)) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (dout.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			char_q <= out_char;
			last_q <= out_last;
		end
	end

	assign dout.valid     = out_valid_q;
	assign dout.character = char_q;
	assign dout.last      = last_q;

endmodule

// ===== sv/sitoa_checker.sv =====
`include "assert_macros.svh"

module sitoa_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] character,
	input logic       last
);

	// a taken item keeps the block busy in the next cycle
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready)

	// a stalled character holds
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(character) && $stable(last))

	// only the minus sign or a decimal digit leaves the block
	`ASSERT_IMPLY(a_char_legal, clk, arst_n, out_valid, character == 8'h2d || (character >= 8'h30 && character <= 8'h39))

	// the sign never ends a number
	`ASSERT_IMPLY(a_sign_not_last, clk, arst_n, out_valid && character == 8'h2d, !last)

endmodule

bind signed_int_to_decimal_ascii_unit sitoa_checker u_sitoa_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (din.valid),
	.in_ready  (din.ready),
	.out_valid (dout.valid),
	.out_ready (dout.ready),
	.character (dout.character),
	.last      (dout.last)
);

// ===== verif/tb_signed_int_to_decimal_ascii_unit.sv =====
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii_unit;
	import sitoa_pkg::*;

	// one character item as it leaves the block
	typedef struct packed {
		logic [7:0] character;
		logic       last;
	} ascii_char_t;

	// directed row: empty text means the predictor supplies the characters
	typedef struct {
		logic [VALUE_WIDTH-1:0] value;
		string                  text;
	} text_row_t;

	localparam int DIRECTED_ROWS    = 20;
	localparam int RANDOM_PER_PHASE = 100;
	localparam int QUIET_LIMIT      = 4000;
	localparam int DRAIN_CYCLES     = 60;

	logic clk;
	logic arst_n;

	sitoa_in_if  in_ch ();
	sitoa_out_if out_ch ();

	signed_int_to_decimal_ascii_unit u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (in_ch),
		.dout   (out_ch)
	);

	ascii_char_t pending_chars [$];
	text_row_t   directed_rows [DIRECTED_ROWS];
	int          mismatch_count = 0;
	int          quiet_cycles   = 0;
	int          send_idle_pct;
	int          recv_idle_pct;

	// 20 ns clock
	initial clk = 1'b0;
	always #10 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		mismatch_count++;
	endtask

	// decimal text of one value: optional sign, then digits, last flag on the final one
	function automatic void predict_decimal_text(input logic [VALUE_WIDTH-1:0] value);
		logic                   negative;
		logic [VALUE_WIDTH-1:0] magnitude;
		logic [7:0]             digits [$];
		negative  = value[VALUE_WIDTH-1];
		magnitude = negative ? -value : value;
		do begin
			digits.push_front(CHAR_ZERO + 8'(magnitude % 10));
			magnitude = magnitude / 10;
		end while (magnitude != 0);
		if (negative)
			pending_chars.push_back('{character: CHAR_MINUS, last: 1'b0});
		foreach (digits[i])
			pending_chars.push_back('{character: digits[i], last: i == digits.size() - 1});
	endfunction

	// mix of full-range words, fixed digit counts, powers of ten and small values
	function automatic logic [VALUE_WIDTH-1:0] random_value();
		longint unsigned        span;
		logic [VALUE_WIDTH-1:0] magnitude;
		int                     digits;
		span      = 1;
		magnitude = '0;
		case ($urandom_range(0, 3))
			0: return $urandom;
			1: begin
				digits = $urandom_range(1, 9);
				repeat (digits) span = span * 10;
				magnitude = VALUE_WIDTH'({32'd0, $urandom} % span);
			end
			2: begin
				digits = $urandom_range(0, 9);
				repeat (digits) span = span * 10;
				magnitude = VALUE_WIDTH'(span - $urandom_range(0, 1));
			end
			default: magnitude = $urandom_range(0, 20);
		endcase
		return $urandom_range(0, 1) ? -magnitude : magnitude;
	endfunction

	// offer one item, wait for the handshake, then queue what it should produce
	task automatic send_value(input logic [VALUE_WIDTH-1:0] value, input string text);
		int i;
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.value <= value;
		do @(posedge clk); while (!in_ch.ready);
		if (text.len() == 0)
			predict_decimal_text(value);
		else
			for (i = 0; i < text.len(); i++)
				pending_chars.push_back('{character: text[i], last: i == text.len() - 1});
	endtask

	// receiver stalls, activity tracking and character checks
	always @(posedge clk) begin
		ascii_char_t want;
		out_ch.ready <= (recv_idle_pct == 0) || ($urandom_range(0, 99) >= recv_idle_pct);
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_chars.size() == 0) begin
				report_mismatch($sformatf("unexpected character 'h%02h last %0b",
					out_ch.character, out_ch.last));
			end else begin
				want = pending_chars.pop_front();
				if (out_ch.character !== want.character)
					report_mismatch($sformatf("character 'h%02h, wanted 'h%02h",
						out_ch.character, want.character));
				if (out_ch.last !== want.last)
					report_mismatch($sformatf("last %0b on character 'h%02h, wanted %0b",
						out_ch.last, want.character, want.last));
			end
		end
	end

	// stop a hung run
	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int phase;
		arst_n        = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.value   = '0;
		out_ch.ready  = 1'b0;
		send_idle_pct = 22;
		recv_idle_pct = 68;

		// extremes, digit-count boundaries and alternating bit patterns
		directed_rows = '{
			'{32'd0,                 "0"},
			'{32'd1,                 "1"},
			'{-32'sd1,               "-1"},
			'{32'h7fff_ffff,         "2147483647"},
			'{32'h8000_0000,         "-2147483648"},
			'{32'h8000_0001,         ""},
			'{32'd9,                 ""},
			'{32'd10,                ""},
			'{-32'sd9,               ""},
			'{-32'sd10,              ""},
			'{32'd99,                ""},
			'{32'd100,               ""},
			'{32'd999999999,         ""},
			'{32'd1000000000,        ""},
			'{-32'sd999999999,       ""},
			'{-32'sd1000000000,      ""},
			'{32'h5555_5555,         ""},
			'{32'haaaa_aaaa,         ""},
			'{32'h0000_ffff,         ""},
			'{32'hffff_0000,         ""}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[r])
			send_value(directed_rows[r].value, directed_rows[r].text);

		// three idling profiles; sender drains the block before the later two
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				1: begin
					send_idle_pct = 68;
					recv_idle_pct = 22;
				end
				2: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
				default: ;
			endcase
			if (phase != 0) begin
				in_ch.valid <= 1'b0;
				while (pending_chars.size() != 0) @(posedge clk);
			end
			repeat (RANDOM_PER_PHASE) send_value(random_value(), "");
		end
		in_ch.valid <= 1'b0;

		// drain, then give stray characters a chance to show up
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
